>>> src/tick_timer_table_defines.svh
// Assertion macros for the timer table module
`ifndef TICK_TIMER_TABLE_DEFINES_SVH
`define TICK_TIMER_TABLE_DEFINES_SVH

// Implication checked every clock outside reset
`define TTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define TTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and codes for the tick timer table.
// ----------------------------------------------------------------------------
package ttt_pkg;
  localparam int TableDepthDef = 16;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // one table entry as stored in memory
  typedef struct packed {
    logic [7:0]  handler;
    logic [31:0] interval;
    logic        one_shot;
  } entry_t;

  // request to the modulo unit and its answer
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic        zero;
  } mod_rsp_t;
endpackage

>>> src/ttt_mod.sv
// ----------------------------------------------------------------------------
// ttt_mod
// Restoring remainder unit, one quotient bit per cycle; reports rem == 0.
// ----------------------------------------------------------------------------
module ttt_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  ttt_pkg::mod_req_t req,
  output ttt_pkg::mod_rsp_t rsp
);
  import ttt_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] div_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    trial    = {rem_r, quo_r[31]} - {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({rem_r, quo_r[31]} >= {1'b0, div_r}) rem_nxt = trial[31:0];
      else rem_nxt = {rem_r[30:0], quo_r[31]};
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) div_r <= req.divisor;
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);
endmodule

>>> src/tick_timer_table.sv
// Add writes the entry when accepted; remove and tick walk the entries one by one,
//   each periodic entry with a nonzero interval also waiting on the bit-serial remainder (32 steps).
// Requests: one at a time, taken only once the previous closing result is gone.
// Reset: synchronous active-low rst_n clears tick counter and entry count;
//   table memory is not cleared, entries above the count are never read.
// ----------------------------------------------------------------------------
// tick_timer_table
// Compacted timer table in one memory with a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module tick_timer_table #(
  parameter int TABLE_DEPTH = ttt_pkg::TableDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] kind, [9:2] handler_id, [41:10] interval, [42] one_shot, zero fill
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] fired, [8:1] fired_handler, [10:9] status, [42:11] tick_count, zero fill
  output logic [47:0] out_tdata,
  output logic        out_tlast
);
  import ttt_pkg::*;
  `include "tick_timer_table_defines.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_EVAL, S_MOD, S_MODW, S_SH_RD, S_SH_WAIT, S_SH_WR, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] tick_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r, sh_r;
  logic [1:0] kind_r;
  logic [7:0] hid_r;
  entry_t cur_r;
  logic resume_r; // after a shift: 0 finish request, 1 continue scan

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata;

  // output register
  logic ov_r, ofire_r, olast_r;
  logic [7:0] oh_r;
  logic [1:0] ost_r;

  mod_req_t mreq;
  mod_rsp_t mrsp;
  ttt_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic out_free;
  logic o_load;
  assign out_free = !ov_r || out_tready;
  assign o_load   = (state_r == S_MODW || state_r == S_OUT) && out_free;
  // tick count and status sit in the output word, so hold off until it drains
  assign in_tready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = cur_r;
    raddr = idx_r[AW-1:0];
    mreq.start = 1'b0; mreq.dividend = tick_r; mreq.divisor = cur_r.interval;
    case (state_r)
      S_IDLE: begin
        we = in_tvalid && in_tready && in_tdata[1:0] == KIND_ADD &&
             cnt_r < CW'(TABLE_DEPTH);
        waddr = cnt_r[AW-1:0];
        wdata = '{handler: in_tdata[9:2], interval: in_tdata[41:10],
                  one_shot: in_tdata[42]};
      end
      S_EVAL: begin
        if (kind_r == KIND_TICK && cur_r.handler != 8'd0 && cur_r.one_shot &&
            cur_r.interval != '0) begin
          we = 1'b1;
          wdata.interval = cur_r.interval - 32'd1;
        end
        mreq.start = kind_r == KIND_TICK && cur_r.handler != 8'd0 &&
                     !cur_r.one_shot && cur_r.interval != '0;
      end
      S_SH_RD, S_SH_WAIT: raddr = AW'(sh_r + CW'(1));
      S_SH_WR: begin
        we = 1'b1; waddr = sh_r[AW-1:0]; wdata = rdata_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (o_load) ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          kind_r <= in_tdata[1:0];
          hid_r  <= in_tdata[9:2];
          idx_r  <= '0;
          ost_r  <= ST_OK;
          case (in_tdata[1:0])
            KIND_TICK: begin
              tick_r  <= tick_r + 32'd1;
              state_r <= S_RD;
            end
            KIND_ADD: begin
              if (cnt_r < CW'(TABLE_DEPTH)) cnt_r <= cnt_r + CW'(1);
              else ost_r <= ST_FULL;
              state_r <= S_OUT;
            end
            KIND_REMOVE: state_r <= S_RD;
            default: state_r <= S_OUT;
          endcase
        end
        S_RD: begin
          if (idx_r >= cnt_r) begin
            if (kind_r == KIND_REMOVE) ost_r <= ST_NOT_FOUND;
            state_r <= S_OUT;
          end else state_r <= S_WAIT;
        end
        S_WAIT: begin
          cur_r   <= rdata_r;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          sh_r <= idx_r;
          if (kind_r == KIND_REMOVE) begin
            if (cur_r.handler == hid_r) begin
              resume_r <= 1'b0;
              state_r  <= S_SH_RD;
            end else begin
              idx_r <= idx_r + CW'(1); state_r <= S_RD;
            end
          end else if (cur_r.handler == 8'd0 ||
                       (cur_r.one_shot && cur_r.interval != '0)) begin
            idx_r <= idx_r + CW'(1); state_r <= S_RD;
          end else if (cur_r.one_shot) begin
            state_r <= S_MODW; // fire, then shift down
          end else if (cur_r.interval == '0) begin
            idx_r <= idx_r + CW'(1); state_r <= S_RD;
          end else state_r <= S_MOD;
        end
        S_MOD: if (mrsp.done) begin
          if (mrsp.zero) state_r <= S_MODW;
          else begin
            idx_r <= idx_r + CW'(1); state_r <= S_RD;
          end
        end
        S_MODW: if (out_free) begin
          ofire_r <= 1'b1; oh_r <= cur_r.handler;
          ost_r <= ST_OK; olast_r <= 1'b0;
          if (cur_r.one_shot) begin
            resume_r <= 1'b1; state_r <= S_SH_RD;
          end else begin
            idx_r <= idx_r + CW'(1); state_r <= S_RD;
          end
        end
        S_SH_RD: begin
          if (sh_r + CW'(1) >= cnt_r) begin
            cnt_r <= cnt_r - CW'(1);
            state_r <= resume_r ? S_RD : S_OUT;
          end else state_r <= S_SH_WAIT;
        end
        S_SH_WAIT: state_r <= S_SH_WR;
        S_SH_WR: begin
          sh_r <= sh_r + CW'(1); state_r <= S_SH_RD;
        end
        S_OUT: if (out_free) begin
          ofire_r <= 1'b0; oh_r <= 8'd0; olast_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, tick_r, ost_r, oh_r, ofire_r};

  `TTT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CW'(TABLE_DEPTH), "entry count beyond depth")
  `TTT_ASSERT_IMP(a_fire_not_last, out_tvalid && out_tdata[0], !out_tlast,
                  "firing result marked last")
  `TTT_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                  "result changed while stalled")
endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_timer_table testbench
// Drives add, remove, tick and bad-kind requests with random gaps and output
// stalls; checks every response against a behavioral model of the table.
// ----------------------------------------------------------------------------
module tb;
  import ttt_pkg::*;

  localparam int DEPTH = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic        fired;
    logic [7:0]  handler;
    logic [1:0]  status;
    logic [31:0] ticks;
    logic        last;
  } rsp_t;

  // timer table model plus queue of pending responses
  class timer_scoreboard;
    logic [31:0] ticks;
    int          count;
    logic [7:0]  hnd [DEPTH];
    logic [31:0] ivl [DEPTH];
    logic        osh [DEPTH];
    rsp_t        pending [$];
    int          errors;

    function void push(logic f, logic [7:0] h, logic [1:0] s, logic l);
      rsp_t r;
      r.fired = f; r.handler = h; r.status = s; r.ticks = ticks; r.last = l;
      pending.push_back(r);
    endfunction

    function void drop(int pos);
      for (int j = pos; j + 1 < count; j++) begin
        hnd[j] = hnd[j+1]; ivl[j] = ivl[j+1]; osh[j] = osh[j+1];
      end
      count--;
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] h, logic [31:0] iv,
                               logic os);
      int i;
      bit hit;
      hit = 0;
      if (kind == KIND_TICK) begin
        ticks++;
        i = 0;
        while (i < count) begin
          if (hnd[i] == 8'd0) begin
            i++;
          end else if (osh[i]) begin
            if (ivl[i] == 32'd0) begin
              push(1'b1, hnd[i], ST_OK, 1'b0);
              drop(i);  // rescan same slot after shift-down
            end else begin
              ivl[i]--;
              i++;
            end
          end else begin
            if (ivl[i] != 32'd0 && ticks % ivl[i] == 32'd0)
              push(1'b1, hnd[i], ST_OK, 1'b0);
            i++;
          end
        end
        push(1'b0, 8'd0, ST_OK, 1'b1);
      end else if (kind == KIND_ADD) begin
        if (count >= DEPTH) begin
          push(1'b0, 8'd0, ST_FULL, 1'b1);
        end else begin
          hnd[count] = h; ivl[count] = iv; osh[count] = os;
          count++;
          push(1'b0, 8'd0, ST_OK, 1'b1);
        end
      end else if (kind == KIND_REMOVE) begin
        for (i = 0; i < count && !hit; i++) begin
          if (hnd[i] == h) begin
            drop(i);
            hit = 1;
          end
        end
        push(1'b0, 8'd0, hit ? ST_OK : ST_NOT_FOUND, 1'b1);
      end else begin
        push(1'b0, 8'd0, ST_OK, 1'b1);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  timer_scoreboard sb;
  int  idle_cycles;
  int  ostall;
  bit  stim_done;
  logic [7:0] live [$];

  tick_timer_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // valid stays up between back-to-back requests; callers drop it when done
  task automatic send(logic [1:0] kind, logic [7:0] h, logic [31:0] iv, logic os);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, os, iv, h, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, h, iv, os);
    if (kind == KIND_ADD) live.push_back(h);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      send(KIND_TICK, 8'($urandom), 32'($urandom), 1'($urandom));
    end else if (sel < 75) begin
      case ($urandom_range(0, 3))
        0: send(KIND_ADD, 8'($urandom), 32'($urandom), 1'($urandom));
        default: send(KIND_ADD, 8'($urandom_range(1, 255)), 32'($urandom_range(0, 6)),
                      1'($urandom));
      endcase
    end else if (sel < 95) begin
      if (live.size() != 0 && $urandom_range(0, 3) != 0)
        send(KIND_REMOVE, live[$urandom_range(0, live.size() - 1)], 32'($urandom),
             1'($urandom));
      else
        send(KIND_REMOVE, 8'($urandom), 32'($urandom), 1'($urandom));
    end else begin
      send(2'd3, 8'($urandom), 32'($urandom), 1'($urandom));
    end
  endtask

  // output side: a random stall before each result
  initial begin
    out_tready = 0;
    ostall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (rst_n)
          sb.check_response({out_tdata[0], out_tdata[8:1], out_tdata[10:9],
                             out_tdata[42:11], out_tlast});
        ostall = $urandom_range(0, 10);
      end
      if (ostall > 0) begin
        out_tready <= 1'b0;
        ostall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else if (!stim_done || sb.pending.size() != 0) idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.ticks = 0; sb.count = 0; sb.errors = 0;
    stim_done = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty tick, remove from empty, fill, full, one-shots, zero handler
    send(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send(KIND_REMOVE, 8'd0, 32'd0, 1'b0);
    send(KIND_ADD, 8'd1, 32'd1, 1'b0);
    send(KIND_ADD, 8'd2, 32'd0, 1'b1);
    send(KIND_ADD, 8'd3, 32'd0, 1'b1);
    send(KIND_ADD, 8'd0, 32'd1, 1'b0);
    send(KIND_ADD, 8'd255, 32'hFFFF_FFFF, 1'b0);
    send(KIND_ADD, 8'd4, 32'd0, 1'b0);
    send(KIND_ADD, 8'd5, 32'd2, 1'b1);
    send(KIND_TICK, 8'd0, 32'd0, 1'b0);
    send(KIND_TICK, 8'd0, 32'd0, 1'b0);
    send(KIND_REMOVE, 8'd0, 32'd0, 1'b0);
    send(KIND_REMOVE, 8'd77, 32'd0, 1'b0);
    for (int k = 0; k < 12; k++) send(KIND_ADD, 8'(10 + k), 32'(k % 3), k[0]);
    send(KIND_TICK, 8'd0, 32'd0, 1'b0);
    send(2'd3, 8'hAA, 32'h5555_5555, 1'b1);
    in_tvalid <= 1'b0;

    // hold off until every response is back
    wait_drained();
    for (int k = 0; k < 125; k++) random_request();
    in_tvalid <= 1'b0;
    stim_done = 1;
    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
